@@ rtl/core/sbp_pkg.sv @@
// Shared constants, types and helpers for the shebang line parser.
`timescale 1ns / 1ps

package sbp_pkg;

	localparam int LINE_MAX_DEF = 256;

	// parse phase codes
	localparam logic [2:0] PH_DONE   = 3'd0;
	localparam logic [2:0] PH_HASH   = 3'd1;
	localparam logic [2:0] PH_BANG   = 3'd2;
	localparam logic [2:0] PH_PRE    = 3'd3;
	localparam logic [2:0] PH_INTERP = 3'd4;
	localparam logic [2:0] PH_GAP    = 3'd5;
	localparam logic [2:0] PH_ARG    = 3'd6;

	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_NL   = 8'h0a;
	localparam logic [7:0] CH_NUL  = 8'h00;

	typedef struct packed {
		logic       is_script;
		logic [7:0] interp_offset;
		logic [8:0] interp_length;
		logic       has_arg;
		logic [7:0] arg_offset;
		logic [8:0] arg_length;
	} result_t;

	function automatic logic is_blank(input logic [7:0] c);
		return c inside {CH_SP, CH_TAB};
	endfunction

	function automatic logic is_term(input logic [7:0] c);
		return c inside {CH_NL, CH_NUL};
	endfunction

endpackage

@@ rtl/core/sbp_parse.sv @@
// Line state registers and the per-byte parse step.
`timescale 1ns / 1ps

module sbp_parse #(
	parameter int LINE_MAX = sbp_pkg::LINE_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  logic [7:0]       byte_in,
	input  logic             start_in,
	input  logic             end_in,
	output logic             emit,
	output sbp_pkg::result_t res
);
	import sbp_pkg::*;

	localparam int PW = $clog2(LINE_MAX + 1);
	localparam int DW = (PW > 9) ? PW : 9;
	localparam logic [DW-1:0] LMAX = DW'(LINE_MAX);

	typedef struct packed {
		logic [2:0]    phase;
		logic [DW-1:0] pos;
		logic [DW-1:0] ib;
		logic [DW-1:0] istop;
		logic [DW-1:0] ab;
		logic [DW-1:0] ae;
	} pst_t;

	typedef struct packed {
		pst_t st;
		logic fire;
		logic ok;
		logic arg;
	} tk_t;

	function automatic tk_t take(input pst_t s, input logic [7:0] c);
		tk_t t;
		t      = '0;
		t.st   = s;
		case (s.phase)
			PH_HASH: begin
				if (c == CH_HASH) t.st.phase = PH_BANG;
				else begin
					t.fire = 1'b1;
					t.st.phase = PH_DONE;
				end
			end
			PH_BANG: begin
				if (c == CH_BANG) t.st.phase = PH_PRE;
				else begin
					t.fire = 1'b1;
					t.st.phase = PH_DONE;
				end
			end
			PH_PRE: begin
				if (is_term(c)) begin
					t.fire = 1'b1;
					t.st.phase = PH_DONE;
				end else if (!is_blank(c)) begin
					t.st.ib = s.pos;
					t.st.phase = PH_INTERP;
				end
			end
			PH_INTERP: begin
				if (is_blank(c)) begin
					t.st.istop = s.pos;
					t.st.phase = PH_GAP;
				end else if (is_term(c)) begin
					t.st.istop = s.pos;
					t.fire = 1'b1;
					t.ok = 1'b1;
					t.st.phase = PH_DONE;
				end
			end
			PH_GAP: begin
				if (is_term(c)) begin
					t.fire = 1'b1;
					t.ok = 1'b1;
					t.st.phase = PH_DONE;
				end else if (!is_blank(c)) begin
					t.st.ab = s.pos;
					t.st.ae = s.pos + 1'b1;
					t.st.phase = PH_ARG;
				end
			end
			PH_ARG: begin
				if (is_term(c)) begin
					t.fire = 1'b1;
					t.ok = 1'b1;
					t.arg = 1'b1;
					t.st.phase = PH_DONE;
				end else if (!is_blank(c)) begin
					t.st.ae = s.pos + 1'b1;
				end
			end
			default: begin
				t.st.phase = PH_DONE;
			end
		endcase
		t.st.pos = s.pos + 1'b1;
		return t;
	endfunction

	pst_t          st_q;
	pst_t          st0;
	tk_t           t1;
	tk_t           t2;
	tk_t           fin;
	logic          skip;
	logic          second;
	logic [DW-1:0] ilen;
	logic [DW-1:0] alen;

	always_comb begin
		st0 = st_q;
		if (start_in) begin
			st0 = '0;
			st0.phase = PH_HASH;
		end
		skip   = (st0.phase == PH_DONE) || (st0.pos >= LMAX);
		t1     = take(st0, byte_in);
		// implied NUL after the last byte or at the length limit
		t2     = take(t1.st, CH_NUL);
		second = !t1.fire && (t1.st.phase != PH_DONE) && (end_in || (t1.st.pos >= LMAX));
		if (skip) begin
			fin = '0;
			fin.st = st0;
		end else if (second) begin
			fin = t2;
		end else begin
			fin = t1;
		end
	end

	assign ilen = fin.st.istop - fin.st.ib;
	assign alen = fin.st.ae - fin.st.ab;
	assign emit = fin.fire;

	always_comb begin
		res = '0;
		if (fin.ok) begin
			res.is_script     = 1'b1;
			res.interp_offset = fin.st.ib[7:0];
			res.interp_length = ilen[8:0];
			if (fin.arg) begin
				res.has_arg    = 1'b1;
				res.arg_offset = fin.st.ab[7:0];
				res.arg_length = alen[8:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= {PH_DONE, {(5 * DW){1'b0}}};
		end else if (step_en) begin
			st_q <= fin.st;
		end
	end

endmodule

@@ rtl/core/shebang_line_parser.sv @@
// Top level of the shebang line parser: word registers and handshake.
//
// Input channel: one byte word per handshake (in_valid / in_ready) with
// line_start marking offset 0 of a line and data_end marking the last byte.
// Output channel: one result word per finished line (out_valid / out_ready)
// giving is_script, interpreter offset/length and argument flag/offset/length.
// A line yields exactly one result: at its newline or NUL, at the NUL implied
// after data_end or at offset LINE_MAX, or as soon as it is rejected.
// Bytes after a decision give nothing until the next line_start.
// A deciding byte passes the input register, then the parse step loads its result into the output register.
// Throughput: one byte per cycle while no deciding byte stalls, set by the combinational parse step
// between the input register and the result register.
// A finished result waits in the output register while the next bytes are
// taken; only a byte that decides a line stalls, and only while the previous
// result is still held by the receiver (in_ready then drops).
// Reset clears the pending words; the parser waits for a line_start byte.
`timescale 1ns / 1ps

module shebang_line_parser #(
	parameter int LINE_MAX = sbp_pkg::LINE_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_value,
	input  logic       line_start,
	input  logic       data_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_script,
	output logic [7:0] interp_offset,
	output logic [8:0] interp_length,
	output logic       has_arg,
	output logic [7:0] arg_offset,
	output logic [8:0] arg_length
);
	import sbp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       end_s1;
	logic       emit;
	logic       advance;
	logic       out_valid_q;
	result_t    res;
	result_t    res_q;

	sbp_parse #(
		.LINE_MAX(LINE_MAX)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.byte_in (byte_s1),
		.start_in(start_s1),
		.end_in  (end_s1),
		.emit    (emit),
		.res     (res)
	);

	assign advance  = valid_s1 && (!emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= byte_value;
			start_s1 <= line_start;
			end_s1   <= data_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign is_script     = res_q.is_script;
	assign interp_offset = res_q.interp_offset;
	assign interp_length = res_q.interp_length;
	assign has_arg       = res_q.has_arg;
	assign arg_offset    = res_q.arg_offset;
	assign arg_length    = res_q.arg_length;

	// never overwrite a result word the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && emit && out_valid_q && !out_ready))
		else $error("result word overwritten while stalled");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |=> out_valid_q)
		else $error("loaded result not presented");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1) && $stable(start_s1)))
		else $error("stalled input word lost");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.is_script) |-> (res_q.interp_offset == 8'd0
			&& res_q.interp_length == 9'd0 && !res_q.has_arg
			&& res_q.arg_offset == 8'd0 && res_q.arg_length == 9'd0))
		else $error("rejected line with nonzero fields");

	a_arg_needs_script: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.has_arg) |-> res_q.is_script)
		else $error("argument flagged on rejected line");

endmodule
